// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker cbad_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPL(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// Next-cycle implication, always checked.
`define CHK_NEXT(lbl, clk, a, b, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/core/cbad_pkg.sv =====
`default_nettype none
package cbad_pkg;

  localparam int NUM_CONTEXTS = 1024;
  localparam int CTX_AW       = $clog2(NUM_CONTEXTS);
  localparam int CTX_W        = 7;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 16;
  localparam logic [5:0] QP_RESET = 6'd26;
  localparam logic [5:0] QP_MAX   = 6'd51;
  localparam logic [8:0] RANGE_INIT = 9'h1FE;

  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_START = 3'd1,
    CMD_INIT  = 3'd2,
    CMD_DEC   = 3'd3,
    CMD_BYP   = 3'd4,
    CMD_TERM  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic [7:0] LPS_TAB [64][4] = '{
    '{128,176,208,240},'{128,167,197,227},'{128,158,187,216},'{123,150,178,205},
    '{116,142,169,195},'{111,135,160,185},'{105,128,152,175},'{100,122,144,166},
    '{ 95,116,137,158},'{ 90,110,130,150},'{ 85,104,123,142},'{ 81, 99,117,135},
    '{ 77, 94,111,128},'{ 73, 89,105,122},'{ 69, 85,100,116},'{ 66, 80, 95,110},
    '{ 62, 76, 90,104},'{ 59, 72, 86, 99},'{ 56, 69, 81, 94},'{ 53, 65, 77, 89},
    '{ 51, 62, 73, 85},'{ 48, 59, 69, 80},'{ 46, 56, 66, 76},'{ 43, 53, 63, 72},
    '{ 41, 50, 59, 69},'{ 39, 48, 56, 65},'{ 37, 45, 54, 62},'{ 35, 43, 51, 59},
    '{ 33, 41, 48, 56},'{ 32, 39, 46, 53},'{ 30, 37, 43, 50},'{ 29, 35, 41, 48},
    '{ 27, 33, 39, 45},'{ 26, 31, 37, 43},'{ 24, 30, 35, 41},'{ 23, 28, 33, 39},
    '{ 22, 27, 32, 37},'{ 21, 26, 30, 35},'{ 20, 24, 29, 33},'{ 19, 23, 27, 31},
    '{ 18, 22, 26, 30},'{ 17, 21, 25, 28},'{ 16, 20, 23, 27},'{ 15, 19, 22, 25},
    '{ 14, 18, 21, 24},'{ 14, 17, 20, 23},'{ 13, 16, 19, 22},'{ 12, 15, 18, 21},
    '{ 12, 14, 17, 20},'{ 11, 14, 16, 19},'{ 11, 13, 15, 18},'{ 10, 12, 15, 17},
    '{ 10, 12, 14, 16},'{  9, 11, 13, 15},'{  9, 11, 12, 14},'{  8, 10, 12, 14},
    '{  8,  9, 11, 13},'{  7,  9, 11, 12},'{  7,  9, 10, 12},'{  7,  8, 10, 11},
    '{  6,  8,  9, 11},'{  6,  7,  9, 10},'{  6,  7,  8,  9},'{  2,  2,  2,  2}
  };

  localparam logic [5:0] NEXT_LPS [64] = '{
     0, 0, 1, 2, 2, 4, 4, 5, 6, 7, 8, 9, 9,11,11,12,
    13,13,15,15,16,16,18,18,19,19,21,21,22,22,23,24,
    24,25,26,26,27,27,28,29,29,30,30,30,31,32,32,33,
    33,33,34,34,35,35,35,36,36,36,37,37,37,38,38,63
  };

  // Doublings needed to bring a 9-bit range back to 0x100 or above (9 for zero).
  function automatic logic [3:0] renorm_shift(input logic [8:0] rng);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 9; i++) begin
      if (rng[i]) n = 4'(8 - i);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cabac_binary_arithmetic_decoder_unit.sv =====
`default_nettype none
// H.264 CABAC bin decoder (9-bit range/offset form). Each input item is one
// command in in_tuser: push a bitstream byte, start the engine, initialize a
// context, or decode a decision, bypass or terminate bin. Every item gives
// exactly one result item with the bin, a status (ok, underflow, buffer
// full), the context entry written (state*2+mps, else 0) and the bits left
// in the 32-bit bit buffer. Decode commands need 9 buffered bits, otherwise
// they report underflow and change nothing. Rate: one item per cycle when
// output is not stalled; items pass the input, then the result register. The
// context store is a 1024x7 RAM with registered read: the read is issued as
// an item is accepted, the decode and the write-back happen when it moves to
// the result register, and a write to the same context from the item just
// ahead is forwarded. slice_qp sits at byte address 0 of the APB port.
// Context entries must be initialized before a decision uses them.
module cabac_binary_arithmetic_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [7:0] data_byte, [17:8] ctx_index, [25:18] init_slope, [33:26] init_offset
  input  wire logic [cbad_pkg::IN_TDATA_W-1:0] in_tdata,
  // [2:0] cmd
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] bin_value, [2:1] status, [9:3] ctx_value, [15:10] bits_held
  output logic [cbad_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import cbad_pkg::*;

  // config register
  logic [5:0] qp_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {26'd0, qp_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_r <= QP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 3'd0) begin
      qp_r <= cfg_pwdata[5:0];
    end
  end

  // input stage
  logic              s1_v_r;
  logic [2:0]        s1_cmd_r;
  logic [7:0]        s1_byte_r;
  logic [CTX_AW-1:0] s1_idx_r;
  logic [7:0]        s1_m_r;
  logic [7:0]        s1_n_r;
  logic              fwd_v_r;
  logic [CTX_W-1:0]  fwd_val_r;

  // engine state
  logic [8:0]  range_r, range_nxt;
  logic [8:0]  offset_r, offset_nxt;
  logic [31:0] buf_r, buf_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic advance, in_acc;
  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  logic [CTX_AW-1:0] in_idx;
  assign in_idx = in_tdata[8 +: CTX_AW];

  logic              ram_we;
  logic [CTX_W-1:0]  ram_rdata;
  logic [CTX_W-1:0]  ctx_nxt;

  cbad_ram #(.WIDTH(CTX_W), .DEPTH(NUM_CONTEXTS)) u_ctx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx_r),
    .wdata (ctx_nxt),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // decode logic
  logic [CTX_W-1:0] ctx_rd;
  logic [31:0] shifted;
  logic [8:0]  win;
  logic        under;
  logic        bin;
  status_t     status;
  // init
  logic [5:0]         qp_sat;
  logic signed [14:0] prod;
  logic signed [11:0] pre;
  logic [6:0]         pre_cl;
  logic [CTX_W-1:0]   init_val;
  // decision
  logic [5:0]  st, st_new;
  logic        mps, mps_new;
  logic [7:0]  rlps;
  logic [8:0]  rng_m;
  // renorm
  logic        do_renorm;
  logic [8:0]  rng1, off1;
  logic [3:0]  nsh;
  logic [17:0] ow;
  logic [9:0]  byp_v;

  assign ctx_rd  = fwd_v_r ? fwd_val_r : ram_rdata;
  assign shifted = buf_r >> (cnt_r - 6'd9);
  assign win     = shifted[8:0];
  assign under   = cnt_r < 6'd9;

  assign qp_sat = (qp_r > QP_MAX) ? QP_MAX : qp_r;
  assign prod   = $signed(s1_m_r) * $signed({1'b0, qp_sat});
  // arithmetic shift gives the floor the standard asks for
  assign pre    = $signed({prod[14], prod[14:4]}) + $signed({{4{s1_n_r[7]}}, s1_n_r});

  always_comb begin
    if (pre < 12'sd1)        pre_cl = 7'd1;
    else if (pre > 12'sd126) pre_cl = 7'd126;
    else                     pre_cl = pre[6:0];
    if (pre_cl <= 7'd63) init_val = {6'(7'd63 - pre_cl), 1'b0};
    else                 init_val = {6'(pre_cl - 7'd64), 1'b1};
  end

  assign st    = ctx_rd[6:1];
  assign mps   = ctx_rd[0];
  assign rlps  = LPS_TAB[st][range_r[7:6]];
  assign rng_m = range_r - {1'b0, rlps};

  always_comb begin
    range_nxt  = range_r;
    offset_nxt = offset_r;
    buf_nxt    = buf_r;
    cnt_nxt    = cnt_r;
    bin        = 1'b0;
    status     = ST_OK;
    ctx_nxt    = '0;
    ram_we     = 1'b0;
    do_renorm  = 1'b0;
    rng1       = range_r;
    off1       = offset_r;
    st_new     = st;
    mps_new    = mps;
    byp_v      = '0;
    case (s1_cmd_r)
      CMD_PUSH: begin
        if (cnt_r > 6'd24) begin
          status = ST_FULL;
        end else begin
          buf_nxt = {buf_r[23:0], s1_byte_r};
          cnt_nxt = cnt_r + 6'd8;
        end
      end
      CMD_INIT: begin
        ctx_nxt = init_val;
        ram_we  = 1'b1;
      end
      CMD_START, CMD_DEC, CMD_BYP, CMD_TERM: begin
        if (under) begin
          status = ST_UNDER;
        end else begin
          case (s1_cmd_r)
            CMD_START: begin
              offset_nxt = win;
              range_nxt  = RANGE_INIT;
              cnt_nxt    = cnt_r - 6'd9;
            end
            CMD_DEC: begin
              if (offset_r >= rng_m) begin
                bin     = !mps;
                off1    = offset_r - rng_m;
                rng1    = {1'b0, rlps};
                mps_new = mps ^ (st == 6'd0);
                st_new  = NEXT_LPS[st];
              end else begin
                bin    = mps;
                off1   = offset_r;
                rng1   = rng_m;
                st_new = (st < 6'd62) ? st + 6'd1 : st;
              end
              do_renorm = 1'b1;
              ctx_nxt   = {st_new, mps_new};
              ram_we    = 1'b1;
            end
            CMD_BYP: begin
              byp_v = {offset_r, win[8]};
              if (byp_v >= {1'b0, range_r}) begin
                bin   = 1'b1;
                byp_v = byp_v - {1'b0, range_r};
              end
              offset_nxt = byp_v[8:0];
              cnt_nxt    = cnt_r - 6'd1;
            end
            default: begin
              rng1 = range_r - 9'd2;
              off1 = offset_r;
              if (offset_r >= rng1) begin
                bin       = 1'b1;
                range_nxt = rng1;
              end else begin
                do_renorm = 1'b1;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    // renormalization: shift range and pull nsh bits into offset
    nsh = renorm_shift(rng1);
    ow  = {off1, win} << nsh;
    if (do_renorm) begin
      range_nxt  = rng1 << nsh;
      offset_nxt = ow[17:9];
      cnt_nxt    = cnt_r - {2'b00, nsh};
    end
    if (!advance) ram_we = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      fwd_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
      range_r  <= RANGE_INIT;
      offset_r <= '0;
      buf_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r  <= 1'b1;
        // item ahead writes the context we just read: take its value
        fwd_v_r <= ram_we && (in_idx == s1_idx_r);
      end else if (advance) begin
        s1_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r  <= 1'b1;
        range_r  <= range_nxt;
        offset_r <= offset_nxt;
        buf_r    <= buf_nxt;
        cnt_r    <= cnt_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_tuser;
      s1_byte_r <= in_tdata[7:0];
      s1_idx_r  <= in_idx;
      s1_m_r    <= in_tdata[25:18];
      s1_n_r    <= in_tdata[33:26];
      fwd_val_r <= ctx_nxt;
    end
    if (advance) begin
      out_data_r <= {cnt_nxt, ctx_nxt, status, bin};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cbad_ram.sv =====
`default_nettype none
module cbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/cbad_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module cbad_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [39:0] in_tdata,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata,
  input wire logic        cfg_pready
);

  `CHK_NEXT(a_rst_idle, clk, !rst_n, !out_tvalid, "result valid right after reset")
  `CHK_IMPL(a_stall_hold, clk, rst_n, $past(out_tvalid && !out_tready) && $past(rst_n), out_tvalid && $stable(out_tdata), "stalled result changed")
  `CHK_IMPL(a_refused_clean, clk, rst_n, out_tvalid && out_tdata[2:1] != 2'd0, out_tdata[0] == 1'b0 && out_tdata[9:3] == 7'd0, "refused command returned a bin or context")
  `CHK_IMPL(a_bits_max, clk, rst_n, out_tvalid, out_tdata[15:10] <= 6'd32, "bit buffer over 32 bits")

endmodule

bind cabac_binary_arithmetic_decoder_unit cbad_chk u_cbad_chk (.*);
`default_nettype wire
